// ===== sv/received_range_coalescer_macros.svh =====
// ---------------------------------------------------------------------------
// Received range coalescer assertion macros
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RECEIVED_RANGE_COALESCER_MACROS_SVH
`define RECEIVED_RANGE_COALESCER_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define RRC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that a trigger implies a consequence in the next cycle
`define RRC_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
// Check that a trigger implies a consequence in the same cycle
`define RRC_ASSERT_SAME(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);
`else
`define RRC_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define RRC_ASSERT_NEXT(label, clk, rst, trig, cons, msg)
`define RRC_ASSERT_SAME(label, clk, rst, trig, cons, msg)
`endif

`endif

// ===== sv/rrc_pkg.sv =====
// ---------------------------------------------------------------------------
// Received range coalescer package
// Widths, status codes and the table port types shared by the design and testbench.
// ---------------------------------------------------------------------------
`default_nettype none

package rrc_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int OFFSET_BITS = 48;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // item field widths
   localparam int CHUNK_END_W  = 48;
   localparam int CHUNK_SIZE_W = 16;
   localparam int VALID_END_W  = 48;
   localparam int STATUS_W     = 2;

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [CNT_W-1:0]       cnt_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SIZE    = 2'd1,
      STATUS_OVERLAP = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   // table write request
   typedef struct packed {
      logic       start_we;
      logic       last_we;
      idx_type    addr;
      offset_type start;
      offset_type last;
   } wr_type;

   // table read request
   typedef struct packed {
      logic    en;
      idx_type addr;
   } rd_req_type;

   // table read data
   typedef struct packed {
      offset_type start;
      offset_type last;
   } rd_type;

endpackage

`default_nettype wire

// ===== sv/rrc_if.sv =====
// ---------------------------------------------------------------------------
// Received range coalescer channels
// Valid/ready channels for chunk items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface rrc_req_if;
   import rrc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CHUNK_END_W-1:0]  chunk_end;
   logic [CHUNK_SIZE_W-1:0] chunk_size;

   modport source (output valid, output chunk_end, output chunk_size, input ready);
   modport sink   (input valid, input chunk_end, input chunk_size, output ready);
endinterface

interface rrc_rsp_if;
   import rrc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [VALID_END_W-1:0] valid_end;
   logic [STATUS_W-1:0]    status;
   logic                   table_empty;

   modport source (output valid, output valid_end, output status, output table_empty,
                   input ready);
   modport sink   (input valid, input valid_end, input status, input table_empty,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/rrc_table.sv =====
// ---------------------------------------------------------------------------
// Received range coalescer block table
// Start and last offset memories, one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module rrc_table (
   input  wire logic            clock,
   input  wire rrc_pkg::rd_req_type rd_req,
   input  wire rrc_pkg::wr_type  wr,
   output      rrc_pkg::rd_type  rd_data
);
   import rrc_pkg::*;

   offset_type start_mem [TABLE_DEPTH];
   offset_type last_mem  [TABLE_DEPTH];
   rd_type     rd_data_ff;

   // write either array at the shared address
   always_ff @(posedge clock) begin
      if (wr.start_we) begin
         start_mem[wr.addr] <= wr.start;
      end
      if (wr.last_we) begin
         last_mem[wr.addr] <= wr.last;
      end
   end

   // read both arrays at one address, hold data otherwise
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff.start <= start_mem[rd_req.addr];
         rd_data_ff.last  <= last_mem[rd_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/received_range_coalescer.sv =====
// Sequencing: one item at a time; after accept the sequencer scans the table, reads the
//   predecessor, decides, moves blocks, writes a new block, reads the tail block and hands
//   over the result; zero-size and size-above-end items go straight to the tail read.
//   A waiting result holds the sequencer. The block table has one read port and one
//   write port (one read, one write per cycle); the next item is taken after the result.
// Reset: synchronous, active high; clears block count, sequencer and result valid.
// ---------------------------------------------------------------------------
// Received range coalescer
// Keeps a sorted table of disjoint received byte ranges and merges each chunk.
// ---------------------------------------------------------------------------
`default_nettype none

`include "received_range_coalescer_macros.svh"

module received_range_coalescer (
   input wire logic clock,
   input wire logic reset,
   rrc_req_if.sink   req_chan,
   rrc_rsp_if.source rsp_chan
);
   import rrc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_PRED_RD,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INS_WR,
      ST_TAIL_RD,
      ST_RESP
   } state_type;

   state_type  state_ff, state_in;
   offset_type end_ff, end_in;
   offset_type start_ff, start_in;
   cnt_type    p_ff, p_in;
   cnt_type    j_ff, j_in;
   cnt_type    count_ff, count_in;
   logic       succ_ff, succ_in;
   offset_type succ_last_ff, succ_last_in;
   logic       remove_ff, remove_in;
   status_type status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALID_END_W-1:0] rsp_end_ff, rsp_end_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   rd_req_type rd_req;
   wr_type     wr;
   rd_type     rd_data;

   offset_type           req_end;
   offset_type           req_size;
   logic [OFFSET_BITS:0] pred_next;
   logic [OFFSET_BITS:0] start_wide;
   cnt_type              p_inc;
   cnt_type              j_inc;
   cnt_type              j_dec;
   logic                 req_fire;

   rrc_table u_table (
      .clock   (clock),
      .rd_req  (rd_req),
      .wr      (wr),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign req_end    = offset_type'(req_chan.chunk_end);
   assign req_size   = offset_type'(req_chan.chunk_size);
   assign pred_next  = {1'b0, rd_data.last} + (OFFSET_BITS + 1)'(1);
   assign start_wide = {1'b0, start_ff};
   assign p_inc      = cnt_type'(p_ff + 1'b1);
   assign j_inc      = cnt_type'(j_ff + 1'b1);
   assign j_dec      = cnt_type'(j_ff - 1'b1);

   // sequence scan, merge decision and table moves
   always_comb begin
      state_in      = state_ff;
      end_in        = end_ff;
      start_in      = start_ff;
      p_in          = p_ff;
      j_in          = j_ff;
      count_in      = count_ff;
      succ_in       = succ_ff;
      succ_last_in  = succ_last_ff;
      remove_in     = remove_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rd_req        = '{en: 1'b0, addr: idx_type'(0)};
      wr            = '{start_we: 1'b0, last_we: 1'b0, addr: idx_type'(0),
                        start: start_ff, last: rd_data.last};

      // drop result once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               end_in    = req_end;
               start_in  = req_end - req_size;
               p_in      = cnt_type'(0);
               succ_in   = 1'b0;
               status_in = STATUS_OK;
               if (req_chan.chunk_size == '0) begin
                  state_in = ST_TAIL_RD;
               end else if (req_size > req_end) begin
                  status_in = STATUS_SIZE;
                  state_in  = ST_TAIL_RD;
               end else if (count_ff == cnt_type'(0)) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end

         // read the block at the scan position
         ST_SCAN_RD: begin
            rd_req   = '{en: 1'b1, addr: p_ff[IDX_W-1:0]};
            state_in = ST_SCAN_CMP;
         end

         // advance past blocks that start below the chunk end
         ST_SCAN_CMP: begin
            if (rd_data.start < end_ff) begin
               p_in = p_inc;
               if (p_inc < count_ff) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_PRED_RD;
               end
            end else begin
               succ_in      = (rd_data.start == end_ff);
               succ_last_in = rd_data.last;
               state_in     = (p_ff == cnt_type'(0)) ? ST_DECIDE : ST_PRED_RD;
            end
         end

         // fetch the predecessor block
         ST_PRED_RD: begin
            rd_req   = '{en: 1'b1, addr: idx_type'(p_ff - 1'b1)};
            state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            state_in = ST_TAIL_RD;
            if (p_ff != cnt_type'(0) && pred_next == start_wide) begin
               // extend the predecessor, absorbing a touching successor
               wr.last_we = 1'b1;
               wr.addr    = idx_type'(p_ff - 1'b1);
               wr.last    = succ_ff ? succ_last_ff : end_ff - offset_type'(1);
               if (succ_ff) begin
                  remove_in = 1'b1;
                  j_in      = p_inc;
                  if (p_inc < count_ff) begin
                     state_in = ST_SHIFT_RD;
                  end else begin
                     count_in = cnt_type'(count_ff - 1'b1);
                  end
               end
            end else if (p_ff != cnt_type'(0) && pred_next > start_wide) begin
               status_in = STATUS_OVERLAP;
            end else if (succ_ff) begin
               // move the successor start down
               wr.start_we = 1'b1;
               wr.addr     = p_ff[IDX_W-1:0];
            end else if (count_ff == cnt_type'(TABLE_DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               remove_in = 1'b0;
               j_in      = cnt_type'(count_ff - 1'b1);
               state_in  = (count_ff == p_ff) ? ST_INS_WR : ST_SHIFT_RD;
            end
         end

         ST_SHIFT_RD: begin
            rd_req   = '{en: 1'b1, addr: j_ff[IDX_W-1:0]};
            state_in = ST_SHIFT_WR;
         end

         // copy one block down for a removal or up for an insert
         ST_SHIFT_WR: begin
            wr.start_we = 1'b1;
            wr.last_we  = 1'b1;
            wr.start    = rd_data.start;
            wr.last     = rd_data.last;
            if (remove_ff) begin
               wr.addr = j_dec[IDX_W-1:0];
               if (j_inc < count_ff) begin
                  j_in     = j_inc;
                  state_in = ST_SHIFT_RD;
               end else begin
                  count_in = cnt_type'(count_ff - 1'b1);
                  state_in = ST_TAIL_RD;
               end
            end else begin
               wr.addr = j_inc[IDX_W-1:0];
               if (j_ff > p_ff) begin
                  j_in     = j_dec;
                  state_in = ST_SHIFT_RD;
               end else begin
                  state_in = ST_INS_WR;
               end
            end
         end

         // write the new block into the opened slot
         ST_INS_WR: begin
            wr.start_we = 1'b1;
            wr.last_we  = 1'b1;
            wr.addr     = p_ff[IDX_W-1:0];
            wr.start    = start_ff;
            wr.last     = end_ff - offset_type'(1);
            count_in    = cnt_type'(count_ff + 1'b1);
            state_in    = ST_TAIL_RD;
         end

         // fetch the highest block for the result
         ST_TAIL_RD: begin
            rd_req   = '{en: count_ff != cnt_type'(0),
                         addr: idx_type'(count_ff - 1'b1)};
            state_in = ST_RESP;
         end

         // hand over the result once the output slot is free
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_empty_in  = (count_ff == cnt_type'(0));
               rsp_end_in    = (count_ff == cnt_type'(0)) ? '0
                                                          : VALID_END_W'(rd_data.last);
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold sequencer state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= cnt_type'(0);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff        <= end_in;
      start_ff      <= start_in;
      p_ff          <= p_in;
      j_ff          <= j_in;
      succ_ff       <= succ_in;
      succ_last_ff  <= succ_last_in;
      remove_ff     <= remove_in;
      status_ff     <= status_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.valid_end   = rsp_end_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.table_empty = rsp_empty_ff;

   // checks
   `RRC_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= cnt_type'(TABLE_DEPTH), "block count above table depth")
   `RRC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_chan.ready, "ready after accepting an item")
   `RRC_ASSERT_SAME(a_empty_end_zero, clock, reset, rsp_valid_ff && rsp_empty_ff, rsp_end_ff == '0, "empty table with nonzero end")
   `RRC_ASSERT_NEXT(a_count_step, clock, reset, 1'b1, count_ff == $past(count_ff) || count_ff == cnt_type'($past(count_ff) + 1'b1) || cnt_type'(count_ff + 1'b1) == $past(count_ff), "block count jumped")

endmodule

`default_nettype wire

// ===== tb/sv/tb_received_range_coalescer.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Received range coalescer testbench
// Drives chunk items through the valid/ready request channel and checks
// every result item against an in-bench copy of the block table. A short
// directed run covers the edge cases; random chunks that mostly fill gaps
// between stored blocks follow, with random idle bursts on both channels.
// ---------------------------------------------------------------------------

module tb_received_range_coalescer;
   import rrc_pkg::*;

   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          RANDOM_ITEMS = 1420;
   localparam int          QUIET_ITEMS  = 150;
   localparam int          DRAIN_CYCLES = 100;
   localparam logic [63:0] MAX_LAST     = (64'd1 << OFFSET_BITS) - 64'd2;

   typedef struct {
      offset_type valid_end;
      status_type status;
      logic       table_empty;
   } range_result_type;

   // Tracks the received ranges and holds the results still due
   class range_scoreboard;
      offset_type       blk_start[TABLE_DEPTH];
      offset_type       blk_last[TABLE_DEPTH];
      int               blk_count;
      range_result_type due_q[$];
      int               errors;

      function new();
         blk_count = 0;
         errors    = 0;
      endfunction

      // Apply one accepted chunk to the table and queue the result it causes
      function void note_chunk(offset_type c_end, logic [CHUNK_SIZE_W-1:0] c_size);
         offset_type       c_start;
         int               p;
         int               i;
         bit               succ;
         status_type       st;
         range_result_type res;
         st = STATUS_OK;
         if (c_size == '0) begin
            st = STATUS_OK;
         end else if ({32'd0, c_size} > c_end) begin
            st = STATUS_SIZE;
         end else begin
            c_start = c_end - offset_type'(c_size);
            p = 0;
            while (p < blk_count && blk_start[p] < c_end) p++;
            succ = (p < blk_count) && (blk_start[p] == c_end);
            if (p > 0 && ({1'b0, blk_last[p-1]} + 49'd1) == {1'b0, c_start}) begin
               // extend predecessor, pull in the successor when it touches
               if (succ) begin
                  blk_last[p-1] = blk_last[p];
                  for (i = p; i + 1 < blk_count; i++) begin
                     blk_start[i] = blk_start[i+1];
                     blk_last[i]  = blk_last[i+1];
                  end
                  blk_count--;
               end else begin
                  blk_last[p-1] = c_end - offset_type'(1);
               end
            end else if (p > 0 && ({1'b0, blk_last[p-1]} + 49'd1) > {1'b0, c_start}) begin
               st = STATUS_OVERLAP;
            end else if (succ) begin
               blk_start[p] = c_start;
            end else if (blk_count >= TABLE_DEPTH) begin
               st = STATUS_FULL;
            end else begin
               // open a new block at p
               for (i = blk_count; i > p; i--) begin
                  blk_start[i] = blk_start[i-1];
                  blk_last[i]  = blk_last[i-1];
               end
               blk_start[p] = c_start;
               blk_last[p]  = c_end - offset_type'(1);
               blk_count++;
            end
         end
         res.valid_end   = (blk_count > 0) ? blk_last[blk_count-1] : '0;
         res.status      = st;
         res.table_empty = (blk_count == 0);
         due_q.push_back(res);
      endfunction

      // Compare one result item with the oldest one due
      function void check_result(offset_type act_end, logic [STATUS_W-1:0] act_status,
                                 logic act_empty);
         range_result_type res;
         if (due_q.size() == 0) begin
            $display("%0t: unexpected result item: valid_end %0h status %0d table_empty %0b",
                     $time, act_end, act_status, act_empty);
            errors++;
            return;
         end
         res = due_q.pop_front();
         if (act_end !== res.valid_end) begin
            $display("%0t: valid_end mismatch: expected %0h actual %0h",
                     $time, res.valid_end, act_end);
            errors++;
         end
         if (act_status !== res.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, res.status, act_status);
            errors++;
         end
         if (act_empty !== res.table_empty) begin
            $display("%0t: table_empty mismatch: expected %0b actual %0b",
                     $time, res.table_empty, act_empty);
            errors++;
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic            clock;
   logic            reset;
   rrc_req_if       req_chan ();
   rrc_rsp_if       rsp_chan ();
   range_scoreboard sb;
   int              cycles = 0;
   int              items_sent;
   int              stall_left;
   bit              quiet;

   received_range_coalescer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_received_range_coalescer failed");
         $finish;
      end
   end

   // Result side: check accepted items, stall ready in random bursts
   initial begin
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.valid_end, rsp_chan.status, rsp_chan.table_empty);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && ((cycles / 400) % 4 != 3) && $urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Present one chunk, hold it until accepted, then maybe idle
   task automatic send_chunk(offset_type c_end, logic [CHUNK_SIZE_W-1:0] c_size);
      req_chan.valid      <= 1'b1;
      req_chan.chunk_end  <= c_end;
      req_chan.chunk_size <= c_size;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sb.note_chunk(c_end, c_size);
      items_sent++;
      if (!quiet && ((items_sent / 50) % 4 != 3) && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Choose the next random chunk from the current table contents
   task automatic pick_chunk(output offset_type c_end, output logic [CHUNK_SIZE_W-1:0] c_size);
      int unsigned r;
      int unsigned g;
      int unsigned mode;
      int unsigned sz;
      int unsigned off;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] len;
      logic [63:0] lim;
      logic [63:0] cap;
      logic [31:0] w0;
      logic [31:0] w1;
      bit          gap_ok;
      // noise: any end, any size
      w0 = $urandom;
      w1 = $urandom;
      c_end  = {w1[15:0], w0};
      c_size = w1[31:16];
      r = $urandom_range(0, 99);
      if (r < 6) begin
         // keep the noise item
      end else if (r < 10) begin
         c_size = '0;
      end else if (r < 14) begin
         c_end  = offset_type'($urandom_range(0, 65534));
         c_size = CHUNK_SIZE_W'($urandom_range(32'(c_end) + 32'd1, 65535));
      end else if (r < 22) begin
         // overlap: end lands inside or just past a stored block
         if (sb.blk_count > 0) begin
            g   = $urandom_range(0, sb.blk_count - 1);
            len = {16'd0, sb.blk_last[g]} - {16'd0, sb.blk_start[g]} + 64'd1;
            lim = (len < 64'd65535) ? len : 64'd65535;
            c_end  = sb.blk_start[g] + offset_type'(1)
                     + offset_type'($urandom_range(0, 32'(lim - 64'd1)));
            lim    = ({16'd0, c_end} < 64'd65535) ? {16'd0, c_end} : 64'd65535;
            c_size = CHUNK_SIZE_W'($urandom_range(1, 32'(lim)));
         end
      end else begin
         // fill part of a gap between stored blocks
         g      = $urandom_range(0, sb.blk_count);
         gap_ok = 1'b1;
         lo     = (g == 0) ? 64'd0 : {16'd0, sb.blk_last[g-1]} + 64'd1;
         if (g == sb.blk_count) begin
            hi = lo + 64'($urandom_range(0, 300));
            if (hi > MAX_LAST) hi = MAX_LAST;
            if (lo > MAX_LAST) gap_ok = 1'b0;
         end else if (sb.blk_start[g] == '0) begin
            gap_ok = 1'b0;
         end else begin
            hi = {16'd0, sb.blk_start[g]} - 64'd1;
         end
         if (gap_ok && lo <= hi) begin
            len  = hi - lo + 64'd1;
            cap  = ($urandom_range(0, 9) == 0) ? 64'd65535 : 64'd64;
            lim  = (len < cap) ? len : cap;
            mode = $urandom_range(0, 99);
            if (mode < 35 && len <= 64'd65535) begin
               c_size = CHUNK_SIZE_W'(len);
               c_end  = offset_type'(hi + 64'd1);
            end else if (mode < 55) begin
               sz     = $urandom_range(1, 32'(lim));
               c_size = CHUNK_SIZE_W'(sz);
               c_end  = offset_type'(lo + 64'(sz));
            end else if (mode < 75 || len < 64'd3) begin
               sz     = $urandom_range(1, 32'(lim));
               c_size = CHUNK_SIZE_W'(sz);
               c_end  = offset_type'(hi + 64'd1);
            end else begin
               lim    = (len - 64'd2 < cap) ? len - 64'd2 : cap;
               sz     = $urandom_range(1, 32'(lim));
               lim    = len - 64'd2 - 64'(sz);
               off    = $urandom_range(0, 32'((lim < 64'd65535) ? lim : 64'd65535));
               c_size = CHUNK_SIZE_W'(sz);
               c_end  = offset_type'(lo + 64'd1 + 64'(off) + 64'(sz));
            end
         end
      end
   endtask

   // Stimulus and end of run
   initial begin
      offset_type              c_end;
      logic [CHUNK_SIZE_W-1:0] c_size;
      int                      k;
      int                      counted;
      sb                  = new();
      items_sent          = 0;
      quiet               = 1'b0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.chunk_end  <= '0;
      req_chan.chunk_size <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero size on an empty table, size above end
      send_chunk(48'd0, 16'd0);
      send_chunk(48'd5, 16'd6);
      // first block, then extend it
      send_chunk(48'd100, 16'd10);
      send_chunk(48'd110, 16'd10);
      // second block, grow it downward by a chunk ending at its start
      send_chunk(48'd200, 16'd20);
      send_chunk(48'd180, 16'd30);
      // close the gap: predecessor and successor merge
      send_chunk(48'd150, 16'd40);
      // overlap with the stored block
      send_chunk(48'd120, 16'd5);
      // no predecessor, then a bridging chunk
      send_chunk(48'd50, 16'd10);
      send_chunk(48'd90, 16'd40);
      // top of the offset space with the largest size
      send_chunk({CHUNK_END_W{1'b1}}, {CHUNK_SIZE_W{1'b1}});
      // fill the table
      for (k = 0; k < TABLE_DEPTH - 2; k++)
         send_chunk(48'd1000 + 48'd100 * offset_type'(k), 16'd10);
      // full table: a new block is dropped, absorb and extend still work
      send_chunk(48'd2400, 16'd10);
      send_chunk(48'd1090, 16'd20);
      send_chunk(48'd1005, 16'd5);

      // random chunks, quiet channels over the last stretch
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         pick_chunk(c_end, c_size);
         send_chunk(c_end, c_size);
         if (c_size != '0) counted++;
      end
      req_chan.valid <= 1'b0;

      // drain outstanding results, then watch for strays
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_received_range_coalescer passed");
      end else begin
         $display("tb_received_range_coalescer failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/rrc_pkg.sv
sv/rrc_if.sv
sv/rrc_table.sv
sv/received_range_coalescer.sv
tb/sv/tb_received_range_coalescer.sv
